### hdl/strobe_delay_pulse_generator_top_assert.svh
// -----------------------------------------------------------------------------
// Strobe delay pulse generator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef STROBE_DELAY_PULSE_GENERATOR_TOP_ASSERT_SVH
`define STROBE_DELAY_PULSE_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SDPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SDPG_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SDPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/sdpg_pkg.sv
// -----------------------------------------------------------------------------
// Strobe delay pulse generator package
// Shared constants, codes and control structs.
// -----------------------------------------------------------------------------
package sdpg_pkg;

   localparam int CHANNELS    = 4;
   localparam int TEST_PERIOD = 100001;
   localparam int TEST_ON_AT  = 100;
   localparam int TEST_RESET  = 25001;

   localparam int ChanW   = 2;
   localparam int TimeW   = 24;
   localparam int TimingW = 2 * TimeW;
   localparam int ModeW   = 2;
   localparam int IndexW  = 3;
   localparam int PhaseW  = 2;
   localparam int TestW   = $clog2(TEST_PERIOD + 1);

   // device modes
   localparam logic [ModeW-1:0] MODE_IDLE   = 2'd0;
   localparam logic [ModeW-1:0] MODE_NORMAL = 2'd1;
   localparam logic [ModeW-1:0] MODE_OTHER  = 2'd2;
   localparam logic [ModeW-1:0] MODE_TEST   = 2'd3;

   // request kinds
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_TRIGGER = 1'b1;

   // register indexes
   localparam logic [IndexW-1:0] CSR_MODE       = 3'd0;
   localparam logic [IndexW-1:0] CSR_CH0_TIMING = 3'd1;

   // channel phases
   localparam logic [PhaseW-1:0] PH_IDLE  = 2'd0;
   localparam logic [PhaseW-1:0] PH_DELAY = 2'd1;
   localparam logic [PhaseW-1:0] PH_PULSE = 2'd2;

   typedef struct packed {
      logic trigger;   // start the delay
      logic count;     // one counting tick
   } chan_ctrl_type;

   typedef struct packed {
      logic set_on;
      logic set_off;
   } chan_level_type;

endpackage

### hdl/strobe_delay_pulse_generator_top.sv
// -----------------------------------------------------------------------------
// Strobe delay pulse generator
// Four-channel triggered one-shot with delay, pulse and a free test pattern.
// -----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Contents
// req_      in         req_tvalid/tready     tdata: channel, tuser: operation
// rsp_      out        rsp_tvalid/tready     tdata: output_levels
// csr_      in         csr_we                csr_index, csr_wdata
//
// One request per cycle while the response is not stalled: a request is held
// in the input register, then all channel and test-counter updates are done in
// one pass of logic and the new levels land in the response register.
// The input register advances whenever the response register is empty or
// being taken, so a stalled response holds one request in each register.
// Reset is synchronous: modes, timing registers, channel phases, levels and
// the test counter (25001) take their reset values.
// -----------------------------------------------------------------------------
`include "strobe_delay_pulse_generator_top_assert.svh"

module strobe_delay_pulse_generator_top
   import sdpg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [1:0] channel
   input  logic [0:0]           req_tuser,   // [0] operation
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [3:0] output_levels
   // register writes
   input  logic                 csr_we,
   input  logic [IndexW-1:0]    csr_index,
   input  logic [TimingW-1:0]   csr_wdata
);

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_op_ff;
   logic [ChanW-1:0]   s1_chan_ff;
   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHANNELS-1:0] rsp_level_ff;
   // block state
   logic [ModeW-1:0]    mode_ff;
   logic [CHANNELS-1:0] level_ff, level_in;
   logic [TestW-1:0]    test_ff, test_in, test_dec;

   logic                advance;
   logic                req_take;
   logic                chan_count;
   logic                test_tick;
   logic [CHANNELS-1:0] on_mask, off_mask;

   chan_ctrl_type       ctrl  [CHANNELS];
   chan_level_type      lreq  [CHANNELS];

   // Move the held request into the response register when there is room.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 8'(rsp_level_ff);

   // Count channels on a tick in either strobe-running mode; test mode
   // drives only the free test counter.
   assign chan_count = advance && (s1_op_ff == OP_TICK)
                       && ((mode_ff == MODE_NORMAL) || (mode_ff == MODE_OTHER));
   assign test_tick  = advance && (s1_op_ff == OP_TICK) && (mode_ff == MODE_TEST);

   for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
      // Triggers only count in strobe-normal mode; a channel number with
      // no channel behind it matches nothing and is dropped.
      assign ctrl[n].trigger = advance && (s1_op_ff == OP_TRIGGER)
                               && (mode_ff == MODE_NORMAL)
                               && (s1_chan_ff == ChanW'(n));
      assign ctrl[n].count   = chan_count;
      assign on_mask[n]      = lreq[n].set_on;
      assign off_mask[n]     = lreq[n].set_off;

      sdpg_channel u_channel (
         .clock        (clock),
         .reset        (reset),
         .timing_we    (csr_we && (csr_index == IndexW'(CSR_CH0_TIMING + n))),
         .timing_wdata (csr_wdata),
         .ctrl         (ctrl[n]),
         .level_req    (lreq[n])
      );
   end

   // Next levels and test counter.
   always_comb begin
      level_in = (level_ff | on_mask) & ~off_mask;
      test_in  = test_ff;
      test_dec = test_ff - 1'b1;
      if (test_tick) begin
         if (test_ff == '0) begin
            // reload from zero without touching the levels
            test_in = TestW'(TEST_PERIOD);
         end else begin
            test_in = test_dec;
            priority if (test_dec == TestW'(TEST_PERIOD - 1)) begin
               level_in = '0;
            end else if (test_dec == TestW'(TEST_ON_AT)) begin
               level_in = '1;
            end else if (test_dec == '0) begin
               test_in = TestW'(TEST_PERIOD);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         level_ff     <= '0;
         test_ff      <= TestW'(TEST_RESET);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_MODE)) begin
            mode_ff <= csr_wdata[ModeW-1:0];
         end
         if (advance) begin
            level_ff <= level_in;
         end
         test_ff <= test_in;
      end
   end

   // Payload registers: capture on the handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_tuser[0];
         s1_chan_ff <= req_tdata[ChanW-1:0];
      end
      if (advance) begin
         rsp_level_ff <= level_in;
      end
   end

   // Assertions
   `SDPG_ASSERT_SAME(a_test_range, clock, reset, 1'b1, test_ff <= TestW'(TEST_PERIOD), "test counter beyond period")
   `SDPG_ASSERT_NEXT(a_rsp_load, clock, reset, advance, rsp_valid_ff && (rsp_level_ff == level_ff), "response does not match levels")
   `SDPG_ASSERT_NEXT(a_idle_mode, clock, reset, advance && (mode_ff == MODE_IDLE), level_ff == $past(level_ff), "levels moved in idle mode")

endmodule

### hdl/sdpg_channel.sv
// -----------------------------------------------------------------------------
// Strobe delay pulse generator channel
// Timing register, phase and countdown of one strobe channel.
// -----------------------------------------------------------------------------
module sdpg_channel
   import sdpg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 timing_we,
   input  logic [TimingW-1:0]   timing_wdata,
   input  chan_ctrl_type        ctrl,
   output chan_level_type       level_req
);

   logic [TimingW-1:0] timing_ff;
   logic [PhaseW-1:0]  phase_ff, phase_in;
   logic [TimeW-1:0]   count_ff, count_in;
   logic [TimeW-1:0]   count_dec;
   logic [TimeW-1:0]   delay_ticks, pulse_ticks;

   assign delay_ticks = timing_ff[TimeW-1:0];
   assign pulse_ticks = timing_ff[TimingW-1:TimeW];
   assign count_dec   = (count_ff != '0) ? count_ff - 1'b1 : '0;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      level_req = '0;
      if (ctrl.trigger) begin
         phase_in = PH_DELAY;
         if (delay_ticks == '0) begin
            level_req.set_on = 1'b1;
            count_in         = TimeW'(1);
         end else begin
            count_in = delay_ticks;
         end
      end else if (ctrl.count) begin
         unique case (phase_ff)
            PH_DELAY: begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  // zero pulse length drops the output on the same tick
                  if (pulse_ticks == '0) begin
                     level_req.set_off = 1'b1;
                     phase_in          = PH_IDLE;
                  end else begin
                     level_req.set_on = 1'b1;
                     phase_in         = PH_PULSE;
                     count_in         = pulse_ticks;
                  end
               end
            end
            PH_PULSE: begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  level_req.set_off = 1'b1;
                  phase_in          = PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= '0;
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
      end else begin
         if (timing_we) begin
            timing_ff <= timing_wdata;
         end
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule
